>>> hdl/lpfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfr_pkg: shared constants for the length-prefixed frame resync block
// Field widths, default store depth and the framing byte codes.
// ----------------------------------------------------------------------------
package lpfr_pkg;

    // default depth of the byte store
    localparam int BUF_DEPTH_DEF = 8192;

    // field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 13;
    localparam int SKIP_W = 13;

    // length limit after reset (5 KiB)
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(5 * 1024);

    // framing codes
    localparam logic [BYTE_W-1:0] END_MARK       = 8'hFF;
    localparam logic [BYTE_W-1:0] HEARTBEAT_TYPE = 8'h0F;

    // 4 length bytes plus one type byte
    localparam int HDR_BYTES = 5;

endpackage

>>> hdl/lpfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lpfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/length_prefixed_frame_resync.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_resync: byte stream deframer with end marker
// Stores received bytes and finds the earliest frame that ends at the newest
// byte: 4-byte little-endian length L, a type byte, L payload bytes (last 0xFF).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received byte per request (i_in_valid / o_in_stall).
//   Output channel: exactly one result request per byte (o_out_valid /
//   i_out_stall) with frame_done, overflow_drop and the found frame's fields.
//   Config: i_cfg_we writes the length limit (max_payload_len); the user must
//   do so only while idle, which the block itself does not enforce.
// Flow:
//   A byte that is not 0xFF, or that leaves five or fewer bytes stored, or
//   hits a full store, goes from IDLE straight to DONE. A 0xFF byte with a
//   length limit of zero goes through SETUP to DONE. Any other 0xFF byte
//   starts a scan of the store through the single RAM read port, one candidate
//   offset per cycle once the window is full, starting at the lowest offset
//   the length limit allows, and ends on a match or after the last candidate.
//   One byte is worked on at a time; o_in_stall is high until its result has
//   been moved to the output register.
// Reset: fill count cleared, limit set to 5120, output empty. The RAM is not
//   cleared; only written positions are read.
// Stall: the output register holds its result while i_out_stall is high; a
//   new byte is still accepted, and its result waits until the slot frees.
// ----------------------------------------------------------------------------
module length_prefixed_frame_resync
    import lpfr_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_wdata,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_byte_in,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_frame_done,
    output logic              o_overflow_drop,
    output logic [SKIP_W-1:0] o_skip_count,
    output logic [LEN_W-1:0]  o_payload_len,
    output logic [BYTE_W-1:0] o_frame_type,
    output logic              o_is_heartbeat
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int CW = $clog2(BUF_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_fill;
    logic [LEN_W-1:0]  r_max;

    // scan control
    logic [AW-1:0]     r_rd_addr;
    logic [AW-1:0]     r_last_addr;
    logic              r_rd_vld;
    logic [2:0]        r_win_cnt;
    logic              r_eval;
    logic [BYTE_W-1:0] r_win [HDR_BYTES];
    logic [AW-1:0]     r_cand;
    logic [CW-1:0]     r_len_exp;

    // pending result
    logic              r_res_done;
    logic              r_res_ovf;
    logic [SKIP_W-1:0] r_res_skip;
    logic [LEN_W-1:0]  r_res_len;
    logic [BYTE_W-1:0] r_res_type;

    // output register
    logic              r_out_vld;
    logic              r_out_done;
    logic              r_out_ovf;
    logic [SKIP_W-1:0] r_out_skip;
    logic [LEN_W-1:0]  r_out_len;
    logic [BYTE_W-1:0] r_out_type;

    logic              in_acc;
    logic              store_full;
    logic              wr_en;
    logic              rd_issue;
    logic              shift_en;
    logic [BYTE_W-1:0] rd_data;
    logic [CW-1:0]     n_fill;
    logic [CW-1:0]     n_diff;
    logic              win_match;
    logic              out_free;

    // handshake
    assign o_in_stall = (r_state != ST_IDLE) || !i_rst_n;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign store_full = (r_fill == CW'(BUF_DEPTH));
    assign wr_en      = in_acc && !store_full;
    assign n_fill     = r_fill + CW'(1);
    assign out_free   = !r_out_vld || !i_out_stall;

    // scan datapath
    assign rd_issue  = (r_state == ST_SCAN) && (r_rd_addr <= r_last_addr);
    assign shift_en  = (r_state == ST_SCAN) && r_rd_vld;
    assign n_diff    = r_fill - CW'(HDR_BYTES);
    assign win_match = ({r_win[3], r_win[2], r_win[1], r_win[0]} == 32'(r_len_exp));

    lpfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_byte_in),
        .i_re    (rd_issue),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_data)
    );

    // sliding window of five stored bytes (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            for (int k = 0; k < HDR_BYTES - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[HDR_BYTES-1] <= rd_data;
        end
    end

    // control, scan sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_max     <= LEN_RESET;
            r_rd_vld  <= 1'b0;
            r_win_cnt <= '0;
            r_eval    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end

            r_rd_vld <= rd_issue;
            r_eval   <= shift_en && (r_win_cnt >= 3'(HDR_BYTES - 1));
            if (shift_en && (r_win_cnt < 3'(HDR_BYTES))) begin
                r_win_cnt <= r_win_cnt + 3'd1;
            end
            if (rd_issue) begin
                r_rd_addr <= r_rd_addr + AW'(1);
            end

            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_res_done <= 1'b0;
                        r_res_skip <= '0;
                        r_res_len  <= '0;
                        r_res_type <= '0;
                        if (store_full) begin
                            r_fill    <= '0;
                            r_res_ovf <= 1'b1;
                            r_state   <= ST_DONE;
                        end else begin
                            r_fill    <= n_fill;
                            r_res_ovf <= 1'b0;
                            if ((i_byte_in == END_MARK) && (n_fill > CW'(HDR_BYTES))) begin
                                r_state <= ST_SETUP;
                            end else begin
                                r_state <= ST_DONE;
                            end
                        end
                    end
                end

                // first candidate offset from the length limit
                ST_SETUP: begin
                    r_win_cnt   <= '0;
                    r_eval      <= 1'b0;
                    r_last_addr <= AW'(r_fill - CW'(2));
                    if (r_max == '0) begin
                        r_state <= ST_DONE;
                    end else if (n_diff > CW'(r_max)) begin
                        r_rd_addr <= AW'(n_diff - CW'(r_max));
                        r_cand    <= AW'(n_diff - CW'(r_max));
                        r_len_exp <= CW'(r_max);
                        r_state   <= ST_SCAN;
                    end else begin
                        r_rd_addr <= '0;
                        r_cand    <= '0;
                        r_len_exp <= n_diff;
                        r_state   <= ST_SCAN;
                    end
                end

                // one candidate per cycle once the window is full
                ST_SCAN: begin
                    if (r_eval) begin
                        if (win_match) begin
                            r_res_done <= 1'b1;
                            r_res_skip <= r_cand[SKIP_W-1:0];
                            r_res_len  <= r_len_exp[LEN_W-1:0];
                            r_res_type <= r_win[HDR_BYTES-1];
                            r_fill     <= '0;
                            r_state    <= ST_DONE;
                        end else if (r_len_exp == CW'(1)) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_len_exp <= r_len_exp - CW'(1);
                            r_cand    <= r_cand + AW'(1);
                        end
                    end
                end

                // hand the result to the output register
                ST_DONE: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_done <= r_res_done;
                        r_out_ovf  <= r_res_ovf;
                        r_out_skip <= r_res_skip;
                        r_out_len  <= r_res_len;
                        r_out_type <= r_res_type;
                        r_state    <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_frame_done    = r_out_done;
    assign o_overflow_drop = r_out_ovf;
    assign o_skip_count    = r_out_skip;
    assign o_payload_len   = r_out_len;
    assign o_frame_type    = r_out_type;
    assign o_is_heartbeat  = r_out_done && (r_out_type == HEARTBEAT_TYPE);

endmodule

>>> hdl/lpfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfr_checker: port-level checks for length_prefixed_frame_resync
// Result field consistency and output hold under stall.
// ----------------------------------------------------------------------------
module lpfr_checker
    import lpfr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_frame_done,
    input logic              o_overflow_drop,
    input logic [SKIP_W-1:0] o_skip_count,
    input logic [LEN_W-1:0]  o_payload_len,
    input logic [BYTE_W-1:0] o_frame_type,
    input logic              o_is_heartbeat
);

    // a dropped byte never completes a frame
    a_drop_not_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_frame_done && o_overflow_drop))
        else $error("frame_done and overflow_drop both set");

    // no frame: all frame fields are zero
    a_no_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_done) |->
            (o_skip_count == '0) && (o_payload_len == '0) &&
            (o_frame_type == '0) && !o_is_heartbeat)
        else $error("frame fields set without a frame");

    // a found frame has a nonzero length
    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> (o_payload_len != '0))
        else $error("frame with zero length");

    // heartbeat flag follows the type byte
    a_heartbeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |->
            (o_is_heartbeat == (o_frame_type == HEARTBEAT_TYPE)))
        else $error("heartbeat flag does not match type");

    // stalled result stays valid and holds its length and skip count
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            o_out_valid && $stable(o_payload_len) && $stable(o_skip_count))
        else $error("stalled result changed");

endmodule

bind length_prefixed_frame_resync lpfr_checker u_lpfr_checker (.*);
